### hdl/vrtf_pkg.sv
// Shared types, constants and helpers for the video RAM tile fetch unit.
package vrtf_pkg;

    localparam int MEM_BYTES  = 8192;
    localparam int TILE_COUNT = 384;
    localparam int BANK_DEPTH = MEM_BYTES / 2;
    localparam int OFF_W      = $clog2(MEM_BYTES);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int TILE_W     = $clog2(TILE_COUNT);
    localparam int EPOCH_W    = 8;

    localparam logic [OFF_W-1:0]   TILE_AREA_END = 13'h1800;
    localparam logic [TILE_W-1:0]  TILE_LAST     = 9'(TILE_COUNT - 1);
    localparam logic [EPOCH_W-1:0] STAMP_CLEAR   = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST   = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX     = '1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FETCH = 2'd2
    } t_op;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    // Planar 2bpp: pixel p takes bit 7-p of each plane, leftmost in bits 15:14.
    function automatic logic [15:0] decode_row(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] pix;
        pix = '0;
        for (int p = 0; p < 8; p++) begin
            pix[15-2*p]  = hi[7-p];
            pix[14-2*p]  = lo[7-p];
        end
        return pix;
    endfunction

endpackage

### hdl/vrtf_if.sv
// Valid/ready channel interfaces for requests and results.
interface vrtf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  write_data;
    logic        high_base;
    logic [7:0]  tile_id;
    logic [2:0]  tile_row;

    modport source(output valid, op, addr, write_data, high_base, tile_id, tile_row,
                   input ready);
    modport sink(input valid, op, addr, write_data, high_base, tile_id, tile_row,
                 output ready);
endinterface

interface vrtf_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [15:0] row_pixels;
    logic [8:0]  tile_index;
    logic        tile_was_dirty;

    modport source(output valid, read_data, row_pixels, tile_index, tile_was_dirty,
                   input ready);
    modport sink(input valid, read_data, row_pixels, tile_index, tile_was_dirty,
                 output ready);
endinterface

### hdl/video_ram_tile_fetch_unit.sv
// Video RAM with byte access and planar 2bpp tile-row fetch, dirty tracking by epoch stamps.
// The result is valid in the cycle after the request transaction (registered RAM read).
// Throughput: one transaction per cycle while the result side takes each result.
// Video bytes sit in two 4096x8 banks (even/odd), so a fetch reads both planes at once.
// Reset: a clearing pass writes every entry of the tile stamp RAM; no request is taken meanwhile.
// The same clearing pass follows every 255th dirty-clearing fetch (epoch wrap).
module video_ram_tile_fetch_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vrtf_req_if.sink       i_req,
    vrtf_rsp_if.source     o_rsp
);

    logic [7:0] mem_lo [vrtf_pkg::BANK_DEPTH];
    logic [7:0] mem_hi [vrtf_pkg::BANK_DEPTH];
    logic [vrtf_pkg::EPOCH_W-1:0] mem_stamp [vrtf_pkg::TILE_COUNT];

    vrtf_pkg::t_state r_state, n_state;
    logic [vrtf_pkg::TILE_W-1:0]  r_cnt, n_cnt;
    logic [vrtf_pkg::EPOCH_W-1:0] r_epoch, n_epoch;
    logic r_any_dirty, n_any_dirty;
    logic r_out_valid;

    logic [1:0]                   r_op;
    logic                         r_sel;
    logic [vrtf_pkg::TILE_W-1:0]  r_idx;
    logic [vrtf_pkg::EPOCH_W-1:0] r_ep;
    logic [7:0]                   r_lo_q, r_hi_q;
    logic [vrtf_pkg::EPOCH_W-1:0] r_stamp_q;

    logic                          sweep;
    logic                          acc;
    logic                          is_wr, is_fetch;
    logic [vrtf_pkg::OFF_W-1:0]    off;
    logic [vrtf_pkg::TILE_W-1:0]   idx;
    logic [vrtf_pkg::BANK_AW-1:0]  bank_addr;
    logic                          in_area;
    logic                          st_we;
    logic [vrtf_pkg::TILE_W-1:0]   st_waddr;
    logic [vrtf_pkg::EPOCH_W-1:0]  st_wdata;
    logic                          wrap;

    assign off       = i_req.addr[vrtf_pkg::OFF_W-1:0];
    assign idx       = {i_req.high_base & ~i_req.tile_id[7], i_req.tile_id};
    assign is_wr     = (i_req.op == vrtf_pkg::OP_WRITE);
    assign is_fetch  = (i_req.op == vrtf_pkg::OP_FETCH);
    assign bank_addr = is_fetch ? {idx, i_req.tile_row} : off[vrtf_pkg::OFF_W-1:1];
    assign in_area   = (off < vrtf_pkg::TILE_AREA_END);
    assign acc       = i_req.valid && i_req.ready;
    assign wrap      = acc && is_fetch && r_any_dirty && (r_epoch == vrtf_pkg::EPOCH_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vrtf_pkg::ST_CLEAR: if (r_cnt == vrtf_pkg::TILE_LAST) n_state = vrtf_pkg::ST_RUN;
            vrtf_pkg::ST_RUN:   if (wrap) n_state = vrtf_pkg::ST_CLEAR;
            default:            n_state = vrtf_pkg::ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        sweep       = 1'b0;
        i_req.ready = 1'b0;
        case (r_state)
            vrtf_pkg::ST_CLEAR: sweep = 1'b1;
            vrtf_pkg::ST_RUN:   i_req.ready = !r_out_valid || o_rsp.ready;
            default:            sweep = 1'b1;
        endcase
    end

    always_comb begin
        n_cnt       = sweep ? r_cnt + 1'b1 : '0;
        n_epoch     = r_epoch;
        n_any_dirty = r_any_dirty;
        if (acc && is_wr && in_area) begin
            n_any_dirty = 1'b1;
        end else if (acc && is_fetch && r_any_dirty) begin
            n_any_dirty = 1'b0;
            n_epoch     = wrap ? vrtf_pkg::EPOCH_FIRST : r_epoch + 1'b1;
        end
    end

    assign st_we    = sweep || (acc && is_wr && in_area);
    assign st_waddr = sweep ? r_cnt : off[vrtf_pkg::OFF_W-1:4];
    assign st_wdata = sweep ? vrtf_pkg::STAMP_CLEAR : r_epoch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vrtf_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_epoch     <= vrtf_pkg::EPOCH_FIRST;
            r_any_dirty <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_epoch     <= n_epoch;
            r_any_dirty <= n_any_dirty;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_req.op;
            r_sel <= off[0];
            r_idx <= idx;
            r_ep  <= r_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_wr && !off[0]) begin
            mem_lo[bank_addr] <= i_req.write_data;
        end
        if (acc) begin
            r_lo_q <= mem_lo[bank_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_wr && off[0]) begin
            mem_hi[bank_addr] <= i_req.write_data;
        end
        if (acc) begin
            r_hi_q <= mem_hi[bank_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_stamp[st_waddr] <= st_wdata;
        end
        if (acc) begin
            r_stamp_q <= mem_stamp[idx];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.read_data      = (r_op == vrtf_pkg::OP_READ) ? (r_sel ? r_hi_q : r_lo_q) : 8'd0;
    assign o_rsp.row_pixels     = (r_op == vrtf_pkg::OP_FETCH) ?
                                  vrtf_pkg::decode_row(r_lo_q, r_hi_q) : 16'd0;
    assign o_rsp.tile_index     = (r_op == vrtf_pkg::OP_FETCH) ? r_idx : '0;
    assign o_rsp.tile_was_dirty = (r_op == vrtf_pkg::OP_FETCH) && (r_stamp_q == r_ep);

    a_no_req_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep |-> !i_req.ready)
        else $error("request taken during stamp clearing pass");

    a_epoch_not_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != vrtf_pkg::STAMP_CLEAR)
        else $error("epoch equals cleared stamp value");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_rsp.valid)
        else $error("no result after accepted transaction");

    a_stall_holds_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> ($stable(r_lo_q) && $stable(r_hi_q)
                                           && $stable(r_stamp_q)))
        else $error("RAM read data changed while result stalled");

    a_wrap_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wrap |=> (sweep && r_epoch == vrtf_pkg::EPOCH_FIRST))
        else $error("epoch wrap did not start a clearing pass");

endmodule

### tb/vrtf_checker.sv
// Scoreboard for the video RAM tile fetch unit: models the memory and checks each result.
`timescale 1ns / 100ps
module vrtf_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    vrtf_req_if     req_mon,
    vrtf_rsp_if     rsp_mon,
    output int      o_fail_count,
    output int      o_pending
);

    typedef struct packed {
        logic [7:0]                  read_data;
        logic [15:0]                 row_pixels;
        logic [vrtf_pkg::TILE_W-1:0] tile_index;
        logic                        tile_was_dirty;
    } t_vram_result;

    logic [7:0]   vram_shadow [vrtf_pkg::MEM_BYTES];
    logic         dirty_shadow [vrtf_pkg::TILE_COUNT];
    logic         dirty_any;
    t_vram_result result_fifo [$];
    int           fail_count;

    initial begin
        for (int i = 0; i < vrtf_pkg::MEM_BYTES; i++) vram_shadow[i] = '0;
        for (int i = 0; i < vrtf_pkg::TILE_COUNT; i++) dirty_shadow[i] = 1'b0;
        dirty_any    = 1'b0;
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_vram_result model_access(input logic [1:0] op,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] wdata,
                                                  input logic high_base,
                                                  input logic [7:0] tile_id,
                                                  input logic [2:0] tile_row);
        t_vram_result                res;
        logic [vrtf_pkg::OFF_W-1:0]  off;
        logic [vrtf_pkg::OFF_W-1:0]  row_base;
        logic [vrtf_pkg::TILE_W-1:0] idx;
        logic [7:0]                  plane0;
        logic [7:0]                  plane1;
        logic [15:0]                 pix;
        res = '0;
        off = addr[vrtf_pkg::OFF_W-1:0];
        case (op)
            vrtf_pkg::OP_WRITE: begin
                vram_shadow[off] = wdata;
                if (off < vrtf_pkg::TILE_AREA_END) begin
                    dirty_shadow[off[vrtf_pkg::OFF_W-1:4]] = 1'b1;
                    dirty_any = 1'b1;
                end
            end
            vrtf_pkg::OP_READ: begin
                res.read_data = vram_shadow[off];
            end
            vrtf_pkg::OP_FETCH: begin
                if (high_base && !tile_id[7])
                    idx = 9'd256 + {1'b0, tile_id};
                else
                    idx = {1'b0, tile_id};
                row_base = {idx, 4'b0000} + {9'd0, tile_row, 1'b0};
                plane0 = vram_shadow[row_base];
                plane1 = vram_shadow[row_base + 13'd1];
                pix = '0;
                for (int b = 7; b >= 0; b--) pix = {pix[13:0], plane1[b], plane0[b]};
                res.row_pixels     = pix;
                res.tile_index     = idx;
                res.tile_was_dirty = dirty_shadow[idx];
                if (dirty_any) begin
                    for (int i = 0; i < vrtf_pkg::TILE_COUNT; i++) dirty_shadow[i] = 1'b0;
                    dirty_any = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_vram_result exp_res;
        logic         bad;
        if (i_rst_n) begin
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (result_fifo.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result transaction with no request pending", $time);
                    fail_count++;
                end else begin
                    exp_res = result_fifo.pop_front();
                    bad = (rsp_mon.read_data      !== exp_res.read_data)  ||
                          (rsp_mon.row_pixels     !== exp_res.row_pixels) ||
                          (rsp_mon.tile_index     !== exp_res.tile_index) ||
                          (rsp_mon.tile_was_dirty !== exp_res.tile_was_dirty);
                    if (bad) begin
                        if (fail_count < 10)
                            $display({"%0t: exp rd=%02h px=%04h idx=%0d dirty=%0b, ",
                                      "got rd=%02h px=%04h idx=%0d dirty=%0b"},
                                     $time, exp_res.read_data, exp_res.row_pixels,
                                     exp_res.tile_index, exp_res.tile_was_dirty,
                                     rsp_mon.read_data, rsp_mon.row_pixels,
                                     rsp_mon.tile_index, rsp_mon.tile_was_dirty);
                        fail_count++;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                result_fifo.push_back(model_access(req_mon.op, req_mon.addr, req_mon.write_data,
                                                   req_mon.high_base, req_mon.tile_id,
                                                   req_mon.tile_row));
        end
        o_fail_count <= fail_count;
        o_pending    <= result_fifo.size();
    end

endmodule

### tb/tb_top.sv
// Top-level testbench: drives reads, writes and tile fetches into the unit and gives the verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1950;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent_items;
    bit   calm_phase;
    bit   written [vrtf_pkg::MEM_BYTES];
    int   written_q [$];

    vrtf_req_if req_ch();
    vrtf_rsp_if rsp_ch();

    video_ram_tile_fetch_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    vrtf_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm_phase) return 0;
        r = $urandom_range(0, 15);
        if (r < 9) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_req(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] wdata, input logic high_base,
                            input logic [7:0] tile_id, input logic [2:0] tile_row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.addr       <= addr;
        req_ch.write_data <= wdata;
        req_ch.high_base  <= high_base;
        req_ch.tile_id    <= tile_id;
        req_ch.tile_row   <= tile_row;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        if (op != OP_UNUSED) sent_items++;
    endtask

    task automatic vram_write(input logic [15:0] addr, input logic [7:0] wdata);
        push_req(vrtf_pkg::OP_WRITE, addr, wdata, 1'($urandom), 8'($urandom), 3'($urandom));
        if (!written[addr[vrtf_pkg::OFF_W-1:0]]) begin
            written[addr[vrtf_pkg::OFF_W-1:0]] = 1'b1;
            written_q.push_back(int'(addr[vrtf_pkg::OFF_W-1:0]));
        end
    endtask

    task automatic vram_read(input logic [15:0] addr);
        push_req(vrtf_pkg::OP_READ, addr, 8'($urandom), 1'($urandom), 8'($urandom),
                 3'($urandom));
    endtask

    task automatic tile_fetch(input logic high_base, input logic [7:0] tile_id,
                              input logic [2:0] tile_row);
        push_req(vrtf_pkg::OP_FETCH, 16'($urandom), 8'($urandom), high_base, tile_id,
                 tile_row);
    endtask

    // Write the row's planes where needed, sometimes touch the tile, then fetch it.
    task automatic fetch_sequence();
        int          idx;
        logic        hb;
        logic [7:0]  tid;
        logic [2:0]  row;
        logic [12:0] row_base;
        idx = $urandom_range(0, vrtf_pkg::TILE_COUNT - 1);
        row = 3'($urandom);
        if (idx < 128) begin
            hb  = 1'b0;
            tid = 8'(idx);
        end else if (idx >= 256) begin
            hb  = 1'b1;
            tid = 8'(idx - 256);
        end else begin
            hb  = 1'($urandom);
            tid = 8'(idx);
        end
        row_base = 13'(idx * 16) + {9'd0, row, 1'b0};
        if (!written[row_base] || $urandom_range(0, 2) == 0)
            vram_write({3'b100, row_base}, 8'($urandom));
        if (!written[row_base + 13'd1] || $urandom_range(0, 2) == 0)
            vram_write({3'b100, row_base + 13'd1}, 8'($urandom));
        if ($urandom_range(0, 3) == 0)
            vram_write({3'b100, 13'(idx * 16) + 13'($urandom_range(0, 15))}, 8'($urandom));
        tile_fetch(hb, tid, row);
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        repeat (5) @(posedge i_clk);
        forever begin
            int hold;
            int gap;
            hold = $urandom_range(1, 20);
            rsp_ch.ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("video_ram_tile_fetch_unit: mismatch");
        $finish;
    end

    initial begin
        int r;
        int wait_cycles;
        int target;
        logic [15:0] addr;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= vrtf_pkg::OP_WRITE;
        req_ch.addr       <= '0;
        req_ch.write_data <= '0;
        req_ch.high_base  <= 1'b0;
        req_ch.tile_id    <= '0;
        req_ch.tile_row   <= '0;
        sent_items = 0;
        calm_phase = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tile edges, both bases, map area, address wrap, unused op
        vram_write(16'h8000, 8'hFF);
        vram_write(16'h8001, 8'h00);
        tile_fetch(1'b0, 8'h00, 3'd0);
        tile_fetch(1'b0, 8'h00, 3'd0);
        vram_write(16'h97FE, 8'hA5);
        vram_write(16'h97FF, 8'h3C);
        tile_fetch(1'b1, 8'h7F, 3'd7);
        vram_write(16'h9800, 8'h12);
        vram_read(16'h9800);
        tile_fetch(1'b1, 8'h7F, 3'd7);
        vram_write(16'h9FFF, 8'h80);
        vram_read(16'h9FFF);
        vram_write(16'h9000, 8'h0F);
        vram_write(16'h9001, 8'hF0);
        tile_fetch(1'b1, 8'h00, 3'd0);
        vram_write(16'h8FFE, 8'h55);
        vram_write(16'h8FFF, 8'hAA);
        tile_fetch(1'b0, 8'hFF, 3'd7);
        tile_fetch(1'b1, 8'hFF, 3'd7);
        vram_write(16'h0000, 8'h81);
        vram_read(16'h8000);
        vram_read(16'hFFFF);
        vram_write(16'h7FFF, 8'h7E);
        vram_read(16'h9FFF);
        push_req(OP_UNUSED, 16'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                 3'($urandom));

        target = sent_items + RANDOM_ITEMS;
        while (sent_items < target) begin
            calm_phase = ((sent_items / 250) % 4) == 2;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                if ($urandom_range(0, 4) == 0)
                    addr = 16'($urandom);
                else
                    addr = {3'b100, 13'($urandom)};
                vram_write(addr, 8'($urandom));
            end else if (r < 60) begin
                if (written_q.size() == 0) begin
                    vram_write(16'h8000, 8'($urandom));
                end
                addr[12:0]  = 13'(written_q[$urandom_range(0, written_q.size() - 1)]);
                addr[15:13] = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'b100;
                vram_read(addr);
            end else if (r < 96) begin
                fetch_sequence();
            end else begin
                push_req(OP_UNUSED, 16'($urandom), 8'($urandom), 1'($urandom),
                         8'($urandom), 3'($urandom));
            end
        end
        req_ch.valid <= 1'b0;
        calm_phase = 1'b0;

        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending != 0) begin
            $display("video_ram_tile_fetch_unit: mismatch");
        end else begin
            repeat (8) @(posedge i_clk);
            if (fail_count == 0 && pending == 0)
                $display("video_ram_tile_fetch_unit: match");
            else
                $display("video_ram_tile_fetch_unit: mismatch");
        end
        $finish;
    end

endmodule
